// File: rtl/core/ulj_pkg.sv
// Shared types and constants for the datagram loss and jitter monitor.
`default_nettype none

package ulj_pkg;

  // Field widths of one received-datagram summary and of one result.
  localparam int LEN_W     = 16;
  localparam int PTYPE_W   = 8;
  localparam int SEQ_W     = 64;
  localparam int SEC_W     = 32;
  localparam int USEC_W    = 20;
  localparam int COUNT_W   = 64;
  localparam int JITTER_W  = 40;

  // Packed stream widths; the data widths are rounded up to whole bytes.
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 296;
  localparam int OUT_TUSER_W = 2;

  // Header layout in bytes.
  localparam int HLEN_W         = 6;
  localparam int HDR_BASE_LEN   = 1;
  localparam int HDR_CID_LEN    = 8;
  localparam int HDR_VER_LEN    = 4;
  localparam int HDR_PROXY4_LEN = 7;
  localparam int HDR_PROXY6_LEN = 19;

  localparam logic [PTYPE_W-1:0] PROXY_IPV4 = 8'd1;
  localparam logic [PTYPE_W-1:0] PROXY_IPV6 = 8'd2;

  // Transit arithmetic.
  localparam int US_PER_SEC    = 1000000;
  localparam int US_MULT_W     = 21;
  localparam int DSEC_W        = SEC_W + 1;
  localparam int DUS_W         = USEC_W + 1;
  localparam int TRANSIT_W     = DSEC_W + US_MULT_W;
  localparam int DIFF_W        = TRANSIT_W + 1;
  localparam int DIFF_CAP_LOG2 = 44;
  localparam int DIFF_CAP_W    = DIFF_CAP_LOG2 + 1;
  localparam int JITTER_GAIN_LOG2 = 4;

  // Defaults for the top-level parameters.
  localparam int JITTER_FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF      = 4;

  typedef struct packed {
    logic [LEN_W-1:0]   packet_length;
    logic               running;
    logic               has_connection_id;
    logic               has_version;
    logic               has_proxy;
    logic [PTYPE_W-1:0] proxy_addr_type;
    logic [SEQ_W-1:0]   sequence_number;
    logic [SEC_W-1:0]   sent_seconds;
    logic [USEC_W-1:0]  sent_microseconds;
    logic [SEC_W-1:0]   arrival_seconds;
    logic [USEC_W-1:0]  arrival_microseconds;
  } ulj_in_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [COUNT_W-1:0] total_bytes;
    logic [SEQ_W-1:0]   seq;
    logic               counted;
    logic               header_error;
    logic               good;
  } ulj_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  total_bytes;
    logic [COUNT_W-1:0]  lost_packets;
    logic [COUNT_W-1:0]  out_of_order_packets;
    logic [SEQ_W-1:0]    highest_sequence;
    logic [JITTER_W-1:0] jitter_q8_us;
    logic                header_error;
    logic                counted;
  } ulj_result_t;

endpackage

`default_nettype wire

// File: rtl/core/udp_stream_loss_jitter_monitor_unit.sv
// Top level of the datagram loss and interarrival jitter monitor.
`default_nettype none

// One summary per received datagram enters on the slave stream and one result leaves on
// the master stream for each, in order. The block takes a new summary every clock cycle
// while its queue has room; a summary's result passes through the five-stage front
// pipeline (header check and byte total, a 33 x 21 bit multiply, transit add, transit
// delta, magnitude and scaling), the queue storage and head registers and the result
// register. A stalled result holds the back end, and a full queue holds the front
// pipeline and the slave stream. The back end updates the sequence and jitter state
// once per cycle while the queue holds an item and the result is not stalled.
// Results carry the running byte total, lost and out-of-order counts, the highest
// sequence number and the smoothed jitter in units of 2^-JITTER_FRAC_BITS microsecond.
// The seq_is_64bit register must be written only while no summary is in flight.
module udp_stream_loss_jitter_monitor_unit import ulj_pkg::*; #(
  parameter int JITTER_FRAC_BITS = JITTER_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // packet_length, has_connection_id, has_version, has_proxy, proxy_addr_type,
  // sequence_number, sent_seconds, sent_microseconds, arrival_seconds,
  // arrival_microseconds, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // running
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // total_bytes, lost_packets, out_of_order_packets, highest_sequence, jitter_q8_us
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // header_error, counted
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int SCALED_W = DIFF_CAP_W + JITTER_FRAC_BITS;
  localparam int ITEM_W   = $bits(ulj_item_t) + SCALED_W;

  logic                seq_is_64bit;
  ulj_in_t             in_item;
  logic                front_valid;
  ulj_item_t           front_item;
  logic [SCALED_W-1:0] front_scaled;
  logic                queue_full;
  logic                head_valid;
  logic [ITEM_W-1:0]   head_data;
  ulj_item_t           head_item;
  logic [SCALED_W-1:0] head_scaled;
  logic                head_pop;
  ulj_result_t         result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_is_64bit <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      seq_is_64bit <= cfg_data;
    end
  end

  always_comb begin
    in_item.packet_length        = s_tdata[15:0];
    in_item.running              = s_tuser;
    in_item.has_connection_id    = s_tdata[16];
    in_item.has_version          = s_tdata[17];
    in_item.has_proxy            = s_tdata[18];
    in_item.proxy_addr_type      = s_tdata[26:19];
    in_item.sequence_number      = s_tdata[90:27];
    in_item.sent_seconds         = s_tdata[122:91];
    in_item.sent_microseconds    = s_tdata[142:123];
    in_item.arrival_seconds      = s_tdata[174:143];
    in_item.arrival_microseconds = s_tdata[194:175];
  end

  ulj_front #(
    .JITTER_FRAC_BITS(JITTER_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .seq_is_64bit (seq_is_64bit),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (in_item),
    .queue_full   (queue_full),
    .out_valid    (front_valid),
    .out_item     (front_item),
    .out_scaled   (front_scaled)
  );

  ulj_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_data  ({front_item, front_scaled}),
    .full     (queue_full),
    .rd_valid (head_valid),
    .rd_data  (head_data),
    .rd_pop   (head_pop)
  );

  assign head_item   = head_data[ITEM_W-1:SCALED_W];
  assign head_scaled = head_data[SCALED_W-1:0];

  ulj_back #(
    .JITTER_FRAC_BITS(JITTER_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (head_valid),
    .in_item    (head_item),
    .in_scaled  (head_scaled),
    .in_pop     (head_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {result.jitter_q8_us, result.highest_sequence,
                    result.out_of_order_packets, result.lost_packets, result.total_bytes};
  assign m_tuser = {result.counted, result.header_error};

endmodule

`default_nettype wire

// File: rtl/core/ulj_front.sv
// Front end: accepts datagram summaries, checks headers and computes scaled transit deltas.
`default_nettype none

module ulj_front import ulj_pkg::*; #(
  parameter int JITTER_FRAC_BITS = JITTER_FRAC_BITS_DEF,
  localparam int SCALED_W = DIFF_CAP_W + JITTER_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                seq_is_64bit,
  input  logic                in_valid,
  output logic                in_ready,
  input  ulj_in_t             in_item,
  input  logic                queue_full,
  output logic                out_valid,
  output ulj_item_t           out_item,
  output logic [SCALED_W-1:0] out_scaled
);

  localparam logic signed [US_MULT_W-1:0] US_MULT = US_MULT_W'(US_PER_SEC);
  localparam logic [DIFF_CAP_W-1:0] DIFF_CAP = DIFF_CAP_W'(1) << DIFF_CAP_LOG2;
  localparam int NUM_STAGES = 5;

  logic                   en;
  logic                   take;
  logic [NUM_STAGES-1:0]  stage_valid;
  logic [COUNT_W-1:0]     byte_total;
  logic signed [TRANSIT_W-1:0] last_transit;

  // Accept-stage classification.
  logic                   cnt_c;
  logic [HLEN_W-1:0]      hlen_c;
  logic                   proxy_bad_c;
  logic                   bad_c;
  logic [COUNT_W-1:0]     bt_next;
  ulj_item_t              item_c;

  // Pipeline registers.
  ulj_item_t              s1_item, s2_item, s3_item, s4_item, s5_item;
  logic                   s1_first, s2_first, s3_first;
  logic signed [DSEC_W-1:0]    s1_dsec;
  logic signed [DUS_W-1:0]     s1_dus, s2_dus;
  logic signed [TRANSIT_W-1:0] s2_prod, s3_transit;
  logic signed [DIFF_W-1:0]    s4_diff;
  logic [SCALED_W-1:0]         s5_scaled;

  logic signed [TRANSIT_W-1:0] prod_c;
  logic signed [TRANSIT_W-1:0] transit_c;
  logic signed [DIFF_W-1:0]    diff_c;
  logic [DIFF_W-1:0]           abs_c;
  logic [DIFF_CAP_W-1:0]       capped_c;

  // The whole pipeline holds while the queue is full.
  assign en       = !queue_full;
  assign in_ready = en;
  assign take     = in_valid && en;

  always_comb begin
    cnt_c       = in_item.running && (in_item.packet_length != '0);
    proxy_bad_c = 1'b0;
    hlen_c      = HLEN_W'(HDR_BASE_LEN);
    if (in_item.has_connection_id) begin
      hlen_c = hlen_c + HLEN_W'(HDR_CID_LEN);
    end
    if (in_item.has_version) begin
      hlen_c = hlen_c + HLEN_W'(HDR_VER_LEN);
    end
    if (in_item.has_proxy) begin
      case (in_item.proxy_addr_type)
        PROXY_IPV4: hlen_c = hlen_c + HLEN_W'(HDR_PROXY4_LEN);
        PROXY_IPV6: hlen_c = hlen_c + HLEN_W'(HDR_PROXY6_LEN);
        default:    proxy_bad_c = 1'b1;
      endcase
    end
    bad_c   = proxy_bad_c || (LEN_W'(hlen_c) > in_item.packet_length);
    bt_next = cnt_c ? byte_total + COUNT_W'(in_item.packet_length) : byte_total;

    item_c.total_bytes  = bt_next;
    item_c.seq          = seq_is_64bit ? in_item.sequence_number
                                       : {32'd0, in_item.sequence_number[31:0]};
    item_c.counted      = cnt_c;
    item_c.header_error = cnt_c && bad_c;
    item_c.good         = cnt_c && !bad_c;
  end

  assign prod_c    = s1_dsec * US_MULT;
  assign transit_c = s2_prod + TRANSIT_W'(s2_dus);

  // The first counted packet measures against itself, so its delta is zero.
  assign diff_c = s3_first ? '0 : DIFF_W'(s3_transit) - DIFF_W'(last_transit);

  always_comb begin
    abs_c    = s4_diff[DIFF_W-1] ? $unsigned(-s4_diff) : $unsigned(s4_diff);
    capped_c = (abs_c > DIFF_W'(DIFF_CAP)) ? DIFF_CAP : abs_c[DIFF_CAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      byte_total   <= '0;
      last_transit <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[NUM_STAGES-2:0], in_valid};
      if (take) begin
        byte_total <= bt_next;
      end
      if (stage_valid[2] && s3_item.good) begin
        last_transit <= s3_transit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item   <= item_c;
      s1_first  <= (byte_total == '0);
      s1_dsec   <= $signed({1'b0, in_item.arrival_seconds})
                 - $signed({1'b0, in_item.sent_seconds});
      s1_dus    <= $signed({1'b0, in_item.arrival_microseconds})
                 - $signed({1'b0, in_item.sent_microseconds});
      s2_item   <= s1_item;
      s2_first  <= s1_first;
      s2_prod   <= prod_c;
      s2_dus    <= s1_dus;
      s3_item   <= s2_item;
      s3_first  <= s2_first;
      s3_transit <= transit_c;
      s4_item   <= s3_item;
      s4_diff   <= diff_c;
      s5_item   <= s4_item;
      s5_scaled <= SCALED_W'(capped_c) << JITTER_FRAC_BITS;
    end
  end

  assign out_valid  = stage_valid[NUM_STAGES-1];
  assign out_item   = s5_item;
  assign out_scaled = s5_scaled;

endmodule

`default_nettype wire

// File: rtl/core/ulj_queue.sv
// Short queue between the front end and the back end, with a registered head.
`default_nettype none

module ulj_queue import ulj_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_pop
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             head_valid;
  logic [WIDTH-1:0] head_data;
  logic             wr;
  logic             load;

  assign full = (count == (AW+1)'(DEPTH));
  assign wr   = wr_valid && !full;
  // The head register refills from non-empty storage whenever it is empty or being taken.
  assign load = (count != '0) && (!head_valid || rd_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (load) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(wr) - (AW+1)'(load);
      if (load) begin
        head_valid <= 1'b1;
      end else if (rd_pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      head_data <= mem[rd_ptr];
    end
  end

  assign rd_valid = head_valid;
  assign rd_data  = head_data;

endmodule

`default_nettype wire

// File: rtl/core/ulj_back.sv
// Back end: updates loss, reorder and jitter state and holds the result register.
`default_nettype none

module ulj_back import ulj_pkg::*; #(
  parameter int JITTER_FRAC_BITS = JITTER_FRAC_BITS_DEF,
  localparam int SCALED_W = DIFF_CAP_W + JITTER_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ulj_item_t           in_item,
  input  logic [SCALED_W-1:0] in_scaled,
  output logic                in_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ulj_result_t         out_result
);

  localparam int JW = SCALED_W + 1;

  logic [SEQ_W-1:0]    max_seq_seen, max_seq_next;
  logic [COUNT_W-1:0]  loss_count, loss_next;
  logic [COUNT_W-1:0]  reorder_count, reorder_next;
  logic [JITTER_W-1:0] jitter_acc, jitter_next;
  logic [SEQ_W-1:0]    gap;
  logic                advance;
  logic signed [JW-1:0] err;
  logic signed [JW-1:0] step;
  logic [JW-1:0]        sum;
  logic                 valid_q;
  ulj_result_t          result_q;

  assign in_pop = in_valid && (!valid_q || out_ready);

  always_comb begin
    // The sequence advances when it exceeds the highest seen, and always after the top value (wrap).
    advance = (max_seq_seen == '1) || (in_item.seq > max_seq_seen);
    gap     = in_item.seq - max_seq_seen - SEQ_W'(1);
    err     = $signed({1'b0, in_scaled}) - $signed(JW'(jitter_acc));
    step    = err >>> JITTER_GAIN_LOG2;
    sum     = JW'(jitter_acc) + $unsigned(step);

    max_seq_next = max_seq_seen;
    loss_next    = loss_count;
    reorder_next = reorder_count;
    jitter_next  = jitter_acc;
    if (in_item.good) begin
      if (advance) begin
        // An exact next sequence gives a zero gap.
        loss_next    = loss_count + gap;
        max_seq_next = in_item.seq;
      end else begin
        reorder_next = reorder_count + COUNT_W'(1);
        if (loss_count != '0) begin
          loss_next = loss_count - COUNT_W'(1);
        end
      end
      jitter_next = (|sum[JW-1:JITTER_W]) ? '1 : sum[JITTER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seq_seen  <= '0;
      loss_count    <= '0;
      reorder_count <= '0;
      jitter_acc    <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (in_pop) begin
        max_seq_seen  <= max_seq_next;
        loss_count    <= loss_next;
        reorder_count <= reorder_next;
        jitter_acc    <= jitter_next;
        valid_q       <= 1'b1;
      end else if (out_ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      result_q.total_bytes          <= in_item.total_bytes;
      result_q.lost_packets         <= loss_next;
      result_q.out_of_order_packets <= reorder_next;
      result_q.highest_sequence     <= max_seq_next;
      result_q.jitter_q8_us         <= jitter_next;
      result_q.header_error         <= in_item.header_error;
      result_q.counted              <= in_item.counted;
    end
  end

  assign out_valid  = valid_q;
  assign out_result = result_q;

endmodule

`default_nettype wire

// File: rtl/core/ulj_checker.sv
// Port-level checks for the datagram loss and jitter monitor, bound to the top level.
`default_nettype none

module ulj_checker import ulj_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic                   cfg_data,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [IN_TDATA_W-1:0]  s_tdata,
  input wire logic                   s_tuser,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [OUT_TUSER_W-1:0] m_tuser
);

  logic                   have_prev;
  logic [OUT_TDATA_W-1:0] prev_tdata;
  logic                   out_xfer;
  logic [COUNT_W-1:0]     ooo_now;
  logic [COUNT_W-1:0]     ooo_prev;

  assign out_xfer = m_tvalid && m_tready;
  assign ooo_now  = m_tdata[191:128];
  assign ooo_prev = prev_tdata[191:128];

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_xfer) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_tdata <= m_tdata;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A rejected header is only reported for a counted packet.
  a_err_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && !m_tuser[1]))
    else $error("header error on an uncounted item");

  // An uncounted item leaves every statistic as the previous result showed it.
  a_idle_item: assert property (@(posedge clk) disable iff (rst)
    out_xfer && have_prev && !m_tuser[1] |-> m_tdata == prev_tdata)
    else $error("uncounted item changed the statistics");

  // The out-of-order count moves by at most one per result.
  a_ooo_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && have_prev |-> ooo_now == ooo_prev || ooo_now == ooo_prev + COUNT_W'(1))
    else $error("out-of-order count jumped");

endmodule

bind udp_stream_loss_jitter_monitor_unit ulj_checker u_ulj_checker (.*);

`default_nettype wire
